// ----- hw/rtl/clipped_line_rasterizer_defines.svh -----
// Assertion macros used by the checker file.
`ifndef CLIPPED_LINE_RASTERIZER_DEFINES_SVH
`define CLIPPED_LINE_RASTERIZER_DEFINES_SVH

// Assert that a implies b at the next clock edge.
`define CLR_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

// Assert that a implies b at the same clock edge.
`define CLR_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/clr_pkg.sv -----
`default_nettype none
package clr_pkg;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 16;

  typedef enum logic [1:0] {
    StPixel    = 2'd0,
    StAccepted = 2'd1,
    StRejected = 2'd2,
    StIdle     = 2'd3
  } status_e;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic [1:0] CFG_X_MIN = 2'd0;
  localparam logic [1:0] CFG_X_MAX = 2'd1;
  localparam logic [1:0] CFG_Y_MIN = 2'd2;
  localparam logic [1:0] CFG_Y_MAX = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] pixel_count;
    logic        last_pixel;
  } rsp_t;

  // Controller to datapath.
  typedef enum logic [3:0] {
    CmdNone,
    CmdLatch,
    CmdEdge,
    CmdDivStart,
    CmdEdgeApply,
    CmdEndMulHi,
    CmdEndHi,
    CmdEndMulLo,
    CmdEndLo,
    CmdAxis,
    CmdIncStart,
    CmdLoadDone,
    CmdReject,
    CmdPixel,
    CmdIdle
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] edge_sel;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic edge_div;    // current edge needs a division
    logic edge_fail;   // current edge rejects without division
    logic apply_fail;  // division result rejects
    logic need_hi;
    logic need_lo;
    logic count_zero;
    logic active;
  } sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/clr_if.sv -----
`default_nettype none
interface clr_req_if;
  logic           valid;
  logic           ready;
  clr_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clr_rsp_if;
  logic           valid;
  logic           ready;
  clr_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/clr_div.sv -----
`default_nettype none
// Restoring signed divider, truncating toward zero, one quotient bit a cycle.
module clr_div #(
  parameter int unsigned NumBits = 48,
  parameter int unsigned DenBits = 26
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [NumBits-1:0] num_i,
  input  wire logic signed [DenBits-1:0] den_i,
  output logic                           busy_o,
  output logic signed [NumBits-1:0]      quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [DenBits-1:0] den_q, den_d;
  logic               neg_q, neg_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [NumBits:0]   trial;
  logic [NumBits-1:0] shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q[NumBits-2:0], quo_q[NumBits-1]};
    trial   = {1'b0, shifted} - {{(NumBits + 1 - DenBits){1'b0}}, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i[NumBits-1] ? NumBits'(-num_i) : NumBits'(num_i);
      den_d  = den_i[DenBits-1] ? DenBits'(-den_i) : DenBits'(den_i);
      neg_d  = num_i[NumBits-1] ^ den_i[DenBits-1];
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[NumBits]) begin
        rem_d = trial[NumBits-1:0];
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? NumBits'(-quo_q) : NumBits'(quo_q);
endmodule
`default_nettype wire

// ----- hw/rtl/clr_datapath.sv -----
`default_nettype none
module clr_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i,
  input  clr_pkg::req_t      req_i,
  input  clr_pkg::ctl_t      ctl_i,
  output clr_pkg::sts_t      sts_o,
  output clr_pkg::rsp_t      rsp_o
);
  localparam int unsigned FB   = clr_pkg::FracBits;
  localparam int unsigned NumW = 18 + FB + 1;
  localparam int unsigned DenW = 18;
  localparam int unsigned TW   = FB + 20;

  logic signed [15:0] wxmin_q, wxmax_q, wymin_q, wymax_q;
  logic signed [17:0] x0_q, y0_q, x1_q, y1_q, dx_q, dy_q;
  logic signed [TW-1:0] lo_q, hi_q;
  logic signed [17:0] d_cur, q_cur;
  logic signed [NumW-1:0] div_num;
  logic signed [DenW-1:0] div_den;
  logic div_start, div_busy;
  logic signed [NumW-1:0] div_q;
  logic signed [TW-1:0] t;
  logic signed [TW+18:0] prod_x_q, prod_y_q;
  logic signed [17:0] mnr_q, mjr_q;
  logic               ymaj_q, neg_q, active_q;
  logic [16:0]        idx_q, end_q;
  logic signed [39:0] acc_q;
  logic signed [33:0] inc_q;
  logic signed [TW-1:0] ulo, uhi;
  logic                 apply_fail;
  logic signed [TW+18:0] hp, hpy;
  logic signed [17:0]   ax, ay, mnr_n, mjr_n, len_abs;
  logic                 swap;
  logic signed [17:0]   moff, joff, px, py;
  clr_pkg::rsp_t        rsp_q, rsp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wxmin_q <= 16'sd0;
      wxmax_q <= 16'sd319;
      wymin_q <= 16'sd0;
      wymax_q <= 16'sd239;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clr_pkg::CFG_X_MIN: wxmin_q <= cfg_data_i;
        clr_pkg::CFG_X_MAX: wxmax_q <= cfg_data_i;
        clr_pkg::CFG_Y_MIN: wymin_q <= cfg_data_i;
        clr_pkg::CFG_Y_MAX: wymax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctl_i.edge_sel)
      2'd0: begin d_cur = dx_q;  q_cur = 18'(wxmin_q) - x0_q; end
      2'd1: begin d_cur = -dx_q; q_cur = x0_q - 18'(wxmax_q); end
      2'd2: begin d_cur = dy_q;  q_cur = 18'(wymin_q) - y0_q; end
      default: begin d_cur = -dy_q; q_cur = y0_q - 18'(wymax_q); end
    endcase
    div_num = NumW'(q_cur) <<< FB;
    div_den = d_cur;
  end

  assign div_start = (ctl_i.cmd == clr_pkg::CmdDivStart) || (ctl_i.cmd == clr_pkg::CmdIncStart);

  clr_div #(.NumBits(NumW), .DenBits(DenW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  (ctl_i.cmd == clr_pkg::CmdIncStart ? NumW'(mnr_q) <<< FB : div_num),
    .den_i  (ctl_i.cmd == clr_pkg::CmdIncStart ? len_abs : div_den),
    .busy_o (div_busy),
    .quot_o (div_q)
  );

  assign t = TW'(div_q);
  assign len_abs = mjr_q[17] ? -mjr_q : mjr_q;

  always_comb begin
    ulo = lo_q;
    uhi = hi_q;
    apply_fail = 1'b0;
    if (d_cur > 0) begin
      if (hi_q < t) apply_fail = 1'b1;
      if (lo_q < t) ulo = t;
    end else begin
      if (t < lo_q) apply_fail = 1'b1;
      if (t < hi_q) uhi = t;
    end
  end

  // Endpoint update: y uses the same rounding on its product.
  assign hp  = prod_x_q + (TW + 19)'(1 <<< (FB - 1));
  assign hpy = prod_y_q + (TW + 19)'(1 <<< (FB - 1));
  assign ax = (y1_q - y0_q);
  assign ay = (x1_q - x0_q);
  assign swap = ((ax[17] ? -ax : ax) > (ay[17] ? -ay : ay));
  assign mnr_n = swap ? ay : ax;
  assign mjr_n = swap ? ax : ay;

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      clr_pkg::CmdLatch: begin
        x0_q <= 18'(signed'(req_i.start_x));
        y0_q <= 18'(signed'(req_i.start_y));
        x1_q <= 18'(signed'(req_i.end_x));
        y1_q <= 18'(signed'(req_i.end_y));
        dx_q <= 18'(signed'(req_i.end_x)) - 18'(signed'(req_i.start_x));
        dy_q <= 18'(signed'(req_i.end_y)) - 18'(signed'(req_i.start_y));
        lo_q <= '0;
        hi_q <= TW'(1 <<< FB);
      end
      clr_pkg::CmdEdgeApply: begin
        lo_q <= ulo;
        hi_q <= uhi;
      end
      clr_pkg::CmdEndMulHi: begin
        prod_x_q <= hi_q * dx_q;
        prod_y_q <= hi_q * dy_q;
      end
      clr_pkg::CmdEndHi: begin
        x1_q <= x0_q + 18'(hp >>> FB);
        y1_q <= y0_q + 18'(hpy >>> FB);
      end
      clr_pkg::CmdEndMulLo: begin
        prod_x_q <= lo_q * dx_q;
        prod_y_q <= lo_q * dy_q;
      end
      clr_pkg::CmdEndLo: begin
        x0_q <= x0_q + 18'(hp >>> FB);
        y0_q <= y0_q + 18'(hpy >>> FB);
      end
      clr_pkg::CmdAxis: begin
        mnr_q  <= mnr_n;
        mjr_q  <= mjr_n;
        ymaj_q <= swap;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      end_q    <= '0;
      acc_q    <= '0;
      inc_q    <= '0;
      neg_q    <= 1'b0;
    end else begin
      case (ctl_i.cmd)
        clr_pkg::CmdLatch, clr_pkg::CmdReject: active_q <= 1'b0;
        clr_pkg::CmdLoadDone: begin
          active_q <= (len_abs != 0);
          idx_q    <= '0;
          end_q    <= 17'(len_abs);
          acc_q    <= '0;
          inc_q    <= (len_abs == 0) ? '0 : 34'(div_q);
          neg_q    <= mjr_q[17];
        end
        clr_pkg::CmdPixel: begin
          idx_q <= idx_q + 1'b1;
          acc_q <= acc_q + 40'(inc_q);
          if (idx_q + 1'b1 >= end_q) active_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign moff = 18'(acc_q >>> FB);
  assign joff = neg_q ? -18'(idx_q) : 18'(idx_q);
  assign px = ymaj_q ? x0_q + moff : x0_q + joff;
  assign py = ymaj_q ? y0_q + joff : y0_q + moff;

  always_comb begin
    rsp_d = '0;
    case (ctl_i.cmd)
      clr_pkg::CmdReject: rsp_d.status = clr_pkg::StRejected;
      clr_pkg::CmdIdle:   rsp_d.status = clr_pkg::StIdle;
      clr_pkg::CmdLoadDone: begin
        rsp_d.status      = clr_pkg::StAccepted;
        rsp_d.pixel_count = len_abs[15:0];
      end
      clr_pkg::CmdPixel: begin
        rsp_d.status     = clr_pkg::StPixel;
        rsp_d.pixel_x    = px[15:0];
        rsp_d.pixel_y    = py[15:0];
        rsp_d.last_pixel = (idx_q + 1'b1 >= end_q);
      end
      default: rsp_d = rsp_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  always_comb begin
    sts_o.div_busy   = div_busy;
    sts_o.edge_div   = (d_cur != 0);
    sts_o.edge_fail  = (d_cur == 0) && (q_cur > 0);
    sts_o.apply_fail = apply_fail;
    sts_o.need_hi    = hi_q < TW'(1 <<< FB);
    sts_o.need_lo    = lo_q > 0;
    sts_o.count_zero = (len_abs == 0);
    sts_o.active     = active_q;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/clr_ctrl.sv -----
`default_nettype none
module clr_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_req_type_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  clr_pkg::sts_t sts_i,
  output clr_pkg::ctl_t ctl_o
);
  typedef enum logic [3:0] {
    SIdle, SEdge, SDivWait, SApply, SMulHi, SEndHi, SMulLo, SEndLo,
    SAxis, SIncStart, SIncWait, SDone
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] edge_q, edge_d;
  logic       ovalid_q, ovalid_d;
  logic       take;

  // A result register decouples the sides: accept when idle and it is empty or leaving.
  assign in_ready_o  = (state_q == SIdle) && (!ovalid_q || out_ready_i);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d    = state_q;
    edge_d     = edge_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    ctl_o.cmd  = clr_pkg::CmdNone;
    ctl_o.edge_sel = edge_q;
    case (state_q)
      SIdle: begin
        if (take) begin
          if (in_req_type_i == clr_pkg::REQ_LOAD) begin
            ctl_o.cmd = clr_pkg::CmdLatch;
            edge_d    = 2'd0;
            state_d   = SEdge;
          end else if (sts_i.active) begin
            ctl_o.cmd = clr_pkg::CmdPixel;
            ovalid_d  = 1'b1;
          end else begin
            ctl_o.cmd = clr_pkg::CmdIdle;
            ovalid_d  = 1'b1;
          end
        end
      end
      SEdge: begin
        if (sts_i.edge_fail) begin
          ctl_o.cmd = clr_pkg::CmdReject;
          ovalid_d  = 1'b1;
          state_d   = SIdle;
        end else if (sts_i.edge_div) begin
          ctl_o.cmd = clr_pkg::CmdDivStart;
          state_d   = SDivWait;
        end else if (edge_q == 2'd3) begin
          state_d = SMulHi;
        end else begin
          edge_d = edge_q + 1'b1;
        end
      end
      SDivWait: if (!sts_i.div_busy) state_d = SApply;
      SApply: begin
        if (sts_i.apply_fail) begin
          ctl_o.cmd = clr_pkg::CmdReject;
          ovalid_d  = 1'b1;
          state_d   = SIdle;
        end else begin
          ctl_o.cmd = clr_pkg::CmdEdgeApply;
          edge_d    = edge_q + 1'b1;
          state_d   = (edge_q == 2'd3) ? SMulHi : SEdge;
        end
      end
      SMulHi: begin
        if (sts_i.need_hi) begin
          ctl_o.cmd = clr_pkg::CmdEndMulHi;
          state_d   = SEndHi;
        end else begin
          state_d = SMulLo;
        end
      end
      SEndHi: begin
        ctl_o.cmd = clr_pkg::CmdEndHi;
        state_d   = SMulLo;
      end
      SMulLo: begin
        if (sts_i.need_lo) begin
          ctl_o.cmd = clr_pkg::CmdEndMulLo;
          state_d   = SEndLo;
        end else begin
          state_d = SAxis;
        end
      end
      SEndLo: begin
        ctl_o.cmd = clr_pkg::CmdEndLo;
        state_d   = SAxis;
      end
      SAxis: begin
        ctl_o.cmd = clr_pkg::CmdAxis;
        state_d   = SIncStart;
      end
      SIncStart: begin
        if (sts_i.count_zero) begin
          state_d = SDone;
        end else begin
          ctl_o.cmd = clr_pkg::CmdIncStart;
          state_d   = SIncWait;
        end
      end
      SIncWait: if (!sts_i.div_busy) state_d = SDone;
      SDone: begin
        // Wait for the result register before writing the load response.
        if (!ovalid_q || out_ready_i) begin
          ctl_o.cmd = clr_pkg::CmdLoadDone;
          ovalid_d  = 1'b1;
          state_d   = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      edge_q   <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      edge_q   <= edge_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/clipped_line_rasterizer.sv -----
// A step request returns one pixel, or an idle status once the segment is
// done, in the next cycle, and can follow its predecessor every cycle while
// results are read. A load walks the four window edges; every edge that needs
// a division holds the controller while the shared serial divider runs, and the
// minor slope costs one more division before an accepted segment shows its
// result; a zero-length segment skips it. A rejection returns as soon as
// the failing edge is known. Results sit in an output register, so a new
// request can be taken in the cycle the previous result is read.
`default_nettype none
module clipped_line_rasterizer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [clr_pkg::CoordBits-1:0] cfg_data_i,
  clr_req_if.sink                            req,
  clr_rsp_if.source                          rsp
);
  clr_pkg::ctl_t ctl;
  clr_pkg::sts_t sts;

  clr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i   (req.valid),
    .in_req_type_i(req.data.req_type),
    .in_ready_o   (req.ready),
    .out_valid_o  (rsp.valid),
    .out_ready_i  (rsp.ready),
    .sts_i        (sts),
    .ctl_o        (ctl)
  );

  clr_datapath u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i(cfg_data_i[15:0]),
    .req_i     (req.data),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .rsp_o     (rsp.data)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/clr_checker.sv -----
`default_nettype none
`include "clipped_line_rasterizer_defines.svh"
module clr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [1:0] status_i,
  input wire logic last_pixel_i,
  input wire logic [15:0] pixel_x_i
);
  `CLR_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `CLR_ASSERT_SAME(a_last_pix, clk_i, rst_ni, out_valid_i && last_pixel_i, status_i == clr_pkg::StPixel)
  `CLR_ASSERT_SAME(a_idle_zero, clk_i, rst_ni, out_valid_i && status_i == clr_pkg::StIdle, pixel_x_i == 16'd0)
  `CLR_ASSERT_NEXT(a_resp, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i || !in_ready_i)
endmodule

bind clipped_line_rasterizer clr_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(req.valid), .in_ready_i(req.ready),
  .out_valid_i(rsp.valid), .out_ready_i(rsp.ready),
  .status_i(rsp.data.status), .last_pixel_i(rsp.data.last_pixel),
  .pixel_x_i(rsp.data.pixel_x)
);
`default_nettype wire
